// ===== sv/float32_truncating_adder_top_assert.svh =====
// assertion macros for the truncating adder
`ifndef FLOAT32_TRUNCATING_ADDER_TOP_ASSERT_SVH
`define FLOAT32_TRUNCATING_ADDER_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define FTA_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FTA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== sv/fta_pkg.sv =====
// ----------------------------------------------------------------------------
// fta_pkg
// types and constants shared by the truncating adder pipeline
// ----------------------------------------------------------------------------
package fta_pkg;

    localparam int unsigned EXP_W  = 8;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned MANT_W = 24;
    localparam int unsigned SHAMT_W = 5;

    localparam logic [EXP_W-1:0] EXP_MASK = 8'hFF;

    // aligned operands, after stage 1
    typedef struct packed {
        logic              bypass;
        logic [31:0]       bypass_val;
        logic              sa;
        logic              sb;
        logic [EXP_W-1:0]  er;
        logic [MANT_W-1:0] ma;
        logic [MANT_W-1:0] mb;
    } align_t;

    // raw sum, after stage 2
    typedef struct packed {
        logic              bypass;
        logic [31:0]       bypass_val;
        logic              zero;
        logic              sr;
        logic [EXP_W-1:0]  er;
        logic [MANT_W-1:0] mr;
        logic [SHAMT_W-1:0] lz;
    } sum_t;

    function automatic logic [SHAMT_W-1:0] lead_zeros(input logic [MANT_W-1:0] m);
        logic [SHAMT_W-1:0] n;
        logic               found;
        n = '0;
        found = 1'b0;
        for (int i = MANT_W - 1; i >= 0; i--) begin
            if (!found) begin
                if (m[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 1'b1;
                end
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/float32_truncating_adder_top.sv =====
// ----------------------------------------------------------------------------
// float32_truncating_adder_top
// simplified single-precision adder, three-stage pipeline
// ----------------------------------------------------------------------------
// s_axis request: tdata = {operand_b, operand_a}, operand_a in bits 31:0.
// m_axis request: tdata = sum_bits, truncated sum with no rounding.
// an accepted request moves through s1_reg, s2_reg and s3_reg to m_tvalid.
// throughput: one request per cycle if not stalled; stage 1 aligns, stage 2
// adds or subtracts and counts leading zeros, stage 3 shifts left and packs.
// the exponent wraps modulo 256; infinity and nan are plain numbers.
// reset empties every stage; results already held are dropped.
// when m_tready is low the pipe holds; bubbles are squeezed out, and
// s_tready falls only when all three stages hold valid requests.
// ----------------------------------------------------------------------------
module float32_truncating_adder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sum_bits[31:0]
);
    import fta_pkg::*;

    align_t      s1_reg, s1_next;
    sum_t        s2_reg, s2_next;
    logic [31:0] s3_reg, s3_next;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;
    logic [MANT_W-1:0] norm;
    logic [EXP_W-1:0]  enorm;

    fta_align u_align (
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .aligned   (s1_next)
    );

    fta_addsub u_addsub (
        .aligned (s1_reg),
        .sum     (s2_next)
    );

    always_comb begin
        adv3 = !v3_reg || m_tready;
        adv2 = !v2_reg || adv3;
        adv1 = !v1_reg || adv2;
        s_tready = adv1;
        norm  = s2_reg.mr << s2_reg.lz;
        enorm = s2_reg.er - EXP_W'(s2_reg.lz);
        if (s2_reg.bypass) begin
            s3_next = s2_reg.bypass_val;
        end else if (s2_reg.zero) begin
            s3_next = '0;
        end else begin
            s3_next = {s2_reg.sr, enorm & EXP_MASK, norm[FRAC_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = s3_reg;

endmodule

// ===== sv/fta_align.sv =====
// ----------------------------------------------------------------------------
// fta_align
// unpack, zero bypass and exponent alignment of the smaller operand
// ----------------------------------------------------------------------------
module fta_align (
    input  logic          [31:0] operand_a,
    input  logic          [31:0] operand_b,
    output fta_pkg::align_t      aligned
);
    import fta_pkg::*;

    logic [EXP_W-1:0]  ea, eb, exp_gap;
    logic [FRAC_W-1:0] fa, fb;
    logic [MANT_W-1:0] ma, mb;
    logic              a_zero, b_zero, a_small;

    always_comb begin
        ea = operand_a[30:23];
        eb = operand_b[30:23];
        fa = operand_a[22:0];
        fb = operand_b[22:0];
        a_zero = (ea == '0) && (fa == '0);
        b_zero = (eb == '0) && (fb == '0);
        ma = {1'b1, fa};
        mb = {1'b1, fb};
        a_small = ea < eb;
        exp_gap = a_small ? (eb - ea) : (ea - eb);

        aligned.bypass     = a_zero || b_zero;
        aligned.bypass_val = a_zero ? operand_b : operand_a;
        aligned.sa = operand_a[31];
        aligned.sb = operand_b[31];
        aligned.er = a_small ? eb : ea;
        aligned.ma = ma;
        aligned.mb = mb;
        if (exp_gap >= EXP_W'(MANT_W)) begin
            if (a_small) aligned.ma = '0;
            else         aligned.mb = '0;
        end else begin
            if (a_small) aligned.ma = ma >> exp_gap;
            else         aligned.mb = mb >> exp_gap;
        end
    end

endmodule

// ===== sv/fta_addsub.sv =====
// ----------------------------------------------------------------------------
// fta_addsub
// mantissa add or subtract with carry renormalize and leading-zero count
// ----------------------------------------------------------------------------
module fta_addsub (
    input  fta_pkg::align_t aligned,
    output fta_pkg::sum_t   sum
);
    import fta_pkg::*;

    logic [MANT_W:0] wide;

    always_comb begin
        sum.bypass     = aligned.bypass;
        sum.bypass_val = aligned.bypass_val;
        sum.zero = 1'b0;
        sum.sr   = aligned.sa;
        sum.er   = aligned.er;
        sum.lz   = '0;
        wide     = {1'b0, aligned.ma} + {1'b0, aligned.mb};
        if (aligned.sa == aligned.sb) begin
            if (wide[MANT_W]) begin
                sum.mr = wide[MANT_W:1];
                sum.er = aligned.er + 1'b1;
            end else begin
                sum.mr = wide[MANT_W-1:0];
            end
        end else begin
            if (aligned.ma > aligned.mb) begin
                sum.mr = aligned.ma - aligned.mb;
            end else begin
                sum.sr = aligned.sb;
                sum.mr = aligned.mb - aligned.ma;
            end
            sum.zero = aligned.ma == aligned.mb;
            sum.lz   = lead_zeros(sum.mr);
        end
    end

endmodule

// ===== sv/fta_checker.sv =====
// ----------------------------------------------------------------------------
// fta_checker
// port-level checks on the truncating adder
// ----------------------------------------------------------------------------
`include "float32_truncating_adder_top_assert.svh"

module fta_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a zero operand a passes operand b through; with m_tready high while the
    // request moves into s2_reg and s3_reg, operand b shows up on m_tdata
    `FTA_ASSERT_NEXT(a_zero_pass, aclk, aresetn,
        s_tvalid && s_tready && s_tdata[30:0] == 31'd0 ##1 m_tready [*2],
        m_tvalid && (m_tdata == $past(s_tdata[63:32], 3)),
        "zero operand not passed through")

    // a stalled result holds
    `FTA_ASSERT_NEXT(hold_out, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result lost on stall")

    // room is always there while the output drains
    `FTA_ASSERT_IMPL(ready_when_drain, aclk, aresetn,
        m_tready, s_tready, "input stalled while output drains")

endmodule

bind float32_truncating_adder_top fta_checker u_fta_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench for the truncating single-precision adder: a table of directed
// operand pairs, then random pairs biased toward near exponents, each sum
// compared with its table entry or a bit-true predictor; both stream sides
// idle at random
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_COUNT = 800;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam logic [31:0] NO_SUM       = 32'hFFFF_FFFF;   // table marker: predict

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // operand_a[31:0], operand_b[63:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // sum_bits[31:0]

    logic [31:0] sum_queue[$];
    int unsigned mismatch_count = 0;
    int unsigned sums_checked = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;      // stretch with no idling on either side

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
    } add_row_t;

    add_row_t directed_rows[] = '{
        '{32'h0000_0000, 32'h1234_5678, 32'h1234_5678},  // zero a passes b
        '{32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF},  // negative zero a
        '{32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000},  // zero b passes a
        '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000},
        '{32'h3F80_0000, 32'hBF80_0000, 32'h0000_0000},  // exact cancellation
        '{32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000},  // carry renormalize
        '{32'h7F80_0000, 32'h7F80_0000, 32'h0000_0000},  // exponent wraps to 0
        '{32'hFF80_0000, 32'hFF80_0000, 32'h8000_0000},
        '{32'h4B80_0000, 32'h3F80_0000, 32'h4B80_0000},  // gap of 24 drops b
        '{32'h3F80_0000, 32'h4B80_0000, 32'h4B80_0000},
        '{32'h4B00_0000, 32'h3F80_0000, NO_SUM},         // gap of 23
        '{32'h0000_0001, 32'h0000_0001, NO_SUM},         // denormals
        '{32'h0000_0001, 32'h8000_0002, NO_SUM},         // underflow wrap
        '{32'h3FFF_FFFF, 32'hBF80_0000, NO_SUM},
        '{32'hBF80_0001, 32'h3F80_0000, NO_SUM},         // sign of larger
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, NO_SUM},         // nan as number
        '{32'h7FFF_FFFF, 32'hFFFF_FFFE, NO_SUM},
        '{32'h4040_0000, 32'hC000_0000, NO_SUM},
        '{32'h0080_0000, 32'h8000_0001, NO_SUM},
        '{32'hAAAA_AAAA, 32'h5555_5555, NO_SUM},
        '{32'h5555_5555, 32'hAAAA_AAAA, NO_SUM}
    };

    float32_truncating_adder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] truncated_sum(input logic [31:0] a, input logic [31:0] b);
        logic        sign_a, sign_b, sign_r;
        logic [7:0]  exp_a, exp_b;
        logic [7:0]  gap;
        logic [7:0]  exp_r;
        logic [24:0] mant_a, mant_b, mant_r;
        sign_a = a[31];
        sign_b = b[31];
        exp_a  = a[30:23];
        exp_b  = b[30:23];
        if (a[30:0] == '0) return b;
        if (b[30:0] == '0) return a;
        mant_a = {2'b01, a[22:0]};
        mant_b = {2'b01, b[22:0]};
        if (exp_a < exp_b) begin
            gap    = exp_b - exp_a;
            mant_a = (gap >= 24) ? '0 : mant_a >> gap;
            exp_r  = exp_b;
        end else begin
            gap    = exp_a - exp_b;
            mant_b = (gap >= 24) ? '0 : mant_b >> gap;
            exp_r  = exp_a;
        end
        if (sign_a == sign_b) begin
            sign_r = sign_a;
            mant_r = mant_a + mant_b;
            if (mant_r[24]) begin
                mant_r = mant_r >> 1;
                exp_r  = exp_r + 8'd1;
            end
        end else begin
            if (mant_a == mant_b) return 32'h0000_0000;
            sign_r = (mant_a > mant_b) ? sign_a : sign_b;
            mant_r = (mant_a > mant_b) ? mant_a - mant_b : mant_b - mant_a;
            while (!mant_r[23]) begin
                mant_r = mant_r << 1;
                exp_r  = exp_r - 8'd1;
            end
        end
        return {sign_r, exp_r, mant_r[22:0]};
    endfunction

    // called at a falling edge; valid stays up between back-to-back requests
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] known_sum);
        logic [31:0] predicted;
        while (!calm && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        predicted = truncated_sum(a, b);
        if (known_sum != NO_SUM && known_sum != predicted)
            $display("table row %h + %h disagrees with predictor: %h vs %h",
                     a, b, known_sum, predicted);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        do @(posedge aclk); while (!s_tready);
        sum_queue.push_back(known_sum != NO_SUM ? known_sum : predicted);
        @(negedge aclk);
    endtask

    // random operand, exponent often near the partner's to reach cancellation
    function automatic logic [31:0] random_operand(input logic [31:0] other);
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(5))
            0: v[30:23] = other[30:23];
            1: v[30:23] = 8'(other[30:23] + $urandom_range(3) - 1);
            2: v = {~other[31], other[30:0] ^ 31'($urandom_range(7))};
            3: v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
            4: v[30:0] = $urandom_range(1) ? '0 : v[30:0];
            default: ;
        endcase
        return v;
    endfunction

    // receiver: random stalls, checks each sum in order
    always @(negedge aclk) begin
        if (aresetn) m_tready <= calm || ($urandom_range(99) >= 37);
    end

    always @(posedge aclk) begin
        logic [31:0] expected;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (sum_queue.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected sum %h with nothing pending", m_tdata);
            end else begin
                expected = sum_queue.pop_front();
                sums_checked <= sums_checked + 1;
                if (m_tdata !== expected) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORTS)
                        $display("sum mismatch: expected %h, got %h", expected, m_tdata);
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d sums pending", cycle_count,
                     sum_queue.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [31:0] a;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].sum);
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            calm = (i >= 300 && i < 400);
            a = $urandom;
            send_pair(a, random_operand(a), NO_SUM);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("checked %0d sums from %0d directed and %0d random operand pairs",
                 sums_checked, directed_rows.size(), RANDOM_COUNT);
        if (mismatch_count == 0 && sum_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
